// ===== sv/iec_serial_bus_controller_macros.svh =====
// Assertion macros for the serial bus controller.
// No dependencies.
`ifndef IEC_SERIAL_BUS_CONTROLLER_MACROS_SVH
`define IEC_SERIAL_BUS_CONTROLLER_MACROS_SVH
// implication checked on every edge out of reset
`define IEC_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define IEC_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/iec_pkg.sv =====
// Package for the serial bus controller: payload types, codes, constants.
// No dependencies.
package iec_pkg;
  localparam int ACK_TIMEOUT_STEPS_DEF = 250;
  localparam int EOI_DETECT_STEPS_DEF = 25;
  localparam int ATN_RESPONSE_US_DEF = 1000;
  localparam int WAIT_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    CFG_PULLUP = 3'd0, CFG_FAST = 3'd1, CFG_LISTEN = 3'd2, CFG_TALK = 3'd3,
    CFG_UNLISTEN = 3'd4, CFG_UNTALK = 3'd5, CFG_OPEN = 3'd6
  } cfg_idx_t;

  localparam logic [3:0] REQ_SEND = 4'd0;
  localparam logic [3:0] REQ_SEND_LAST = 4'd1;
  localparam logic [3:0] REQ_RECV = 4'd2;
  localparam logic [3:0] REQ_LISTEN = 4'd3;
  localparam logic [3:0] REQ_TALK = 4'd4;
  localparam logic [3:0] REQ_UNLISTEN = 4'd5;
  localparam logic [3:0] REQ_UNTALK = 4'd6;
  localparam logic [3:0] REQ_FRX = 4'd7;
  localparam logic [3:0] REQ_FTX = 4'd8;
  localparam logic [3:0] REQ_CLR = 4'd9;
  localparam logic [3:0] K_LISTEN2 = 4'd10;
  localparam logic [3:0] K_TALK2 = 4'd11;

  typedef struct packed {
    logic       req_valid;
    logic [3:0] req_type;
    logic [7:0] tx_byte;
    logic [4:0] device_number;
    logic [3:0] secondary_address;
    logic       tick;
    logic       clk_level;
    logic       data_level;
  } in_item_t;

  typedef struct packed {
    logic       atn_pull;
    logic       clk_pull;
    logic       data_pull;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       eoi_seen;
    logic       error_flag;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pullup_settle_us;
    logic [3:0] ticks_per_fast_cycle;
    logic [7:0] listen_code;
    logic [7:0] talk_code;
    logic [7:0] unlisten_code;
    logic [7:0] untalk_code;
    logic [7:0] open_channel_code;
  } cfg_t;

  // front-end classification of one item
  typedef struct packed {
    logic       req;      // valid known command
    logic [3:0] kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       tick;
    logic       clk_level;
    logic       data_level;
  } cmd_item_t;

  function automatic logic [7:0] frx_clk_mask(input logic [1:0] k);
    case (k)
      2'd0: return 8'h80;
      2'd1: return 8'h40;
      2'd2: return 8'h08;
      default: return 8'h04;
    endcase
  endfunction
  function automatic logic [7:0] frx_dat_mask(input logic [1:0] k);
    case (k)
      2'd0: return 8'h20;
      2'd1: return 8'h10;
      2'd2: return 8'h02;
      default: return 8'h01;
    endcase
  endfunction
  function automatic logic [7:0] ftx_clk_mask(input logic [1:0] k);
    case (k)
      2'd0: return 8'h08;
      2'd1: return 8'h04;
      2'd2: return 8'h80;
      default: return 8'h40;
    endcase
  endfunction
  function automatic logic [7:0] ftx_dat_mask(input logic [1:0] k);
    case (k)
      2'd0: return 8'h02;
      2'd1: return 8'h01;
      2'd2: return 8'h20;
      default: return 8'h10;
    endcase
  endfunction
endpackage

// ===== sv/iec_front.sv =====
// Front end: holds configuration and turns an input item into a command item.
// Depends on iec_pkg.
module iec_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  iec_pkg::in_item_t in_item,
  output iec_pkg::cmd_item_t cmd,
  output iec_pkg::cfg_t    cfg
);
  import iec_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{8'd5, 4'd1, 8'd32, 8'd64, 8'd63, 8'd95, 8'd96};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULLUP:   cfg_r.pullup_settle_us <= cfg_data;
        CFG_FAST:     cfg_r.ticks_per_fast_cycle <= cfg_data[3:0];
        CFG_LISTEN:   cfg_r.listen_code <= cfg_data;
        CFG_TALK:     cfg_r.talk_code <= cfg_data;
        CFG_UNLISTEN: cfg_r.unlisten_code <= cfg_data;
        CFG_UNTALK:   cfg_r.untalk_code <= cfg_data;
        CFG_OPEN:     cfg_r.open_channel_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.req = in_item.req_valid && (in_item.req_type <= REQ_CLR);
    cmd.kind = in_item.req_type;
    cmd.tick = in_item.tick;
    cmd.clk_level = in_item.clk_level;
    cmd.data_level = in_item.data_level;
    cmd.second_byte = cfg_r.open_channel_code + {4'd0, in_item.secondary_address};
    case (in_item.req_type)
      REQ_LISTEN:   cmd.first_byte = cfg_r.listen_code + {3'd0, in_item.device_number};
      REQ_TALK:     cmd.first_byte = cfg_r.talk_code + {3'd0, in_item.device_number};
      REQ_UNLISTEN: cmd.first_byte = cfg_r.unlisten_code;
      REQ_UNTALK:   cmd.first_byte = cfg_r.untalk_code;
      default:      cmd.first_byte = in_item.tx_byte;
    endcase
  end

  assign cfg = cfg_r;
endmodule

// ===== sv/iec_queue.sv =====
// Short queue between front and back; one write, one read per cycle.
// Depends on iec_pkg.
module iec_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  iec_pkg::cmd_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output iec_pkg::cmd_item_t rd_data,
  output logic               empty
);
  import iec_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_item_t mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;

  assign full = (cnt_r == (PW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end
endmodule

// ===== sv/iec_back.sv =====
// Back end: bus sequencer, one transition per command item, result register.
// Depends on iec_pkg and the assertion macros.
module iec_back #(
  parameter int ACK_TIMEOUT_STEPS = iec_pkg::ACK_TIMEOUT_STEPS_DEF,
  parameter int EOI_DETECT_STEPS = iec_pkg::EOI_DETECT_STEPS_DEF,
  parameter int ATN_RESPONSE_US = iec_pkg::ATN_RESPONSE_US_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  iec_pkg::cfg_t       cfg,
  input  logic                cmd_valid,
  input  iec_pkg::cmd_item_t  cmd,
  output logic                cmd_take,
  output logic                out_valid,
  input  logic                out_stall,
  output iec_pkg::out_item_t  out_item
);
  import iec_pkg::*;
  `include "iec_serial_bus_controller_macros.svh"

  typedef enum logic [5:0] {
    PH_IDLE, PH_ATN_WAIT, PH_TX_READY, PH_TX_NONEOI, PH_TX_SETUP, PH_TX_VALID,
    PH_TX_SETTLE, PH_TX_ACK, PH_TX_GAP, PH_LAST_HIGH, PH_LAST_LOW,
    PH_ATN_RELEASE, PH_TURN_SETTLE, PH_TURN_WAIT, PH_REL_CLK, PH_REL_DATA,
    PH_RX_READY, PH_RX_EOI, PH_RX_EOI_HOLD, PH_RX_EOI_START, PH_RX_BIT_HIGH,
    PH_RX_BIT_LOW, PH_RX_ACK_HOLD, PH_FRX_START, PH_FRX_WAIT, PH_FRX_END,
    PH_FTX_START, PH_FTX_GO, PH_FTX_WAIT, PH_FTX_END
  } phase_t;

  localparam logic [WAIT_W-1:0] W_ATN = WAIT_W'(ATN_RESPONSE_US);
  localparam logic [WAIT_W-1:0] W_ACK = WAIT_W'(ACK_TIMEOUT_STEPS - 1);
  localparam logic [WAIT_W-1:0] W_EOI = WAIT_W'(EOI_DETECT_STEPS - 1);
  localparam logic [WAIT_W-1:0] W_BIT = WAIT_W'(60);
  localparam logic [WAIT_W-1:0] W_NONEOI = WAIT_W'(40);
  localparam logic [WAIT_W-1:0] W_GAP = WAIT_W'(100);
  localparam logic [WAIT_W-1:0] W_ATNREL = WAIT_W'(20);
  localparam logic [3:0] ACK_POLL = 4'd4;
  localparam logic [3:0] EOI_POLL = 4'd10;

  phase_t phase_r, phase_nxt;
  logic [3:0] kind_r, kind_nxt, bcnt_r, bcnt_nxt;
  logic [7:0] sh_r, sh_nxt, sec_r, sec_nxt, rcv_r, rcv_nxt;
  logic [WAIT_W-1:0] wt_r, wt_nxt, wdec;
  logic eoi_r, eoi_nxt, err_r, err_nxt, done;
  logic atn_r, atn_nxt, ck_r, ck_nxt, dt_r, dt_nxt;
  logic tmo;
  logic [WAIT_W-1:0] fc, f16;
  logic [1:0] k;
  out_item_t res_r;
  logic oval_r;

  // an item is consumed whenever the result register can take its result
  assign cmd_take = cmd_valid && (!oval_r || !out_stall);

  assign fc = WAIT_W'(cfg.ticks_per_fast_cycle);
  assign f16 = fc << 4;
  assign wdec = (wt_r != '0 && cmd.tick) ? wt_r - 1'b1 : wt_r;
  assign tmo = (wdec == '0);

  always_comb begin
    phase_nxt = phase_r; kind_nxt = kind_r; bcnt_nxt = bcnt_r; sh_nxt = sh_r;
    sec_nxt = sec_r; rcv_nxt = rcv_r; wt_nxt = wt_r; eoi_nxt = eoi_r;
    err_nxt = err_r; atn_nxt = atn_r; ck_nxt = ck_r; dt_nxt = dt_r; done = 1'b0;
    k = bcnt_r[1:0];
    unique case (phase_r)
      PH_IDLE: if (cmd.req) begin
        bcnt_nxt = '0;
        case (cmd.kind)
          REQ_SEND: begin
            kind_nxt = cmd.kind; sh_nxt = cmd.first_byte; ck_nxt = 1'b0;
            phase_nxt = PH_TX_READY;
          end
          REQ_SEND_LAST: begin
            kind_nxt = cmd.kind; sh_nxt = cmd.first_byte; ck_nxt = 1'b0;
            phase_nxt = PH_LAST_HIGH;
          end
          REQ_RECV: begin
            kind_nxt = cmd.kind; eoi_nxt = 1'b0; phase_nxt = PH_RX_READY;
          end
          REQ_LISTEN, REQ_TALK, REQ_UNLISTEN, REQ_UNTALK: begin
            kind_nxt = cmd.kind; sh_nxt = cmd.first_byte; sec_nxt = cmd.second_byte;
            atn_nxt = 1'b1; ck_nxt = 1'b1; wt_nxt = W_ATN; phase_nxt = PH_ATN_WAIT;
          end
          REQ_FRX: begin kind_nxt = cmd.kind; phase_nxt = PH_FRX_START; end
          REQ_FTX: begin
            kind_nxt = cmd.kind; sh_nxt = cmd.first_byte; phase_nxt = PH_FTX_START;
          end
          default: begin err_nxt = 1'b0; done = 1'b1; end
        endcase
      end
      PH_ATN_WAIT: begin
        wt_nxt = wdec;
        if (tmo) begin
          if (cmd.data_level) begin err_nxt = 1'b1; atn_nxt = 1'b0; ck_nxt = 1'b0; end
          if (cmd.data_level || err_r) begin phase_nxt = PH_IDLE; done = 1'b1; end
          else begin ck_nxt = 1'b0; phase_nxt = PH_TX_READY; end
        end
      end
      PH_TX_READY: if (cmd.data_level) begin wt_nxt = W_NONEOI; phase_nxt = PH_TX_NONEOI; end
      PH_TX_NONEOI: begin
        wt_nxt = wdec;
        if (tmo) begin
          ck_nxt = 1'b1; bcnt_nxt = '0; dt_nxt = !sh_r[0];
          wt_nxt = W_BIT; phase_nxt = PH_TX_SETUP;
        end
      end
      PH_TX_SETUP: begin
        wt_nxt = wdec;
        if (tmo) begin ck_nxt = 1'b0; wt_nxt = W_BIT; phase_nxt = PH_TX_VALID; end
      end
      PH_TX_VALID: begin
        wt_nxt = wdec;
        if (tmo) begin
          ck_nxt = 1'b1; sh_nxt = sh_r >> 1; bcnt_nxt = bcnt_r + 1'b1;
          if (bcnt_r < 4'd7) begin
            dt_nxt = !sh_r[1]; wt_nxt = W_BIT; phase_nxt = PH_TX_SETUP;
          end else begin
            dt_nxt = 1'b0; wt_nxt = WAIT_W'(cfg.pullup_settle_us);
            phase_nxt = PH_TX_SETTLE;
          end
        end
      end
      PH_TX_SETTLE: begin
        wt_nxt = wdec;
        if (tmo) begin wt_nxt = W_ACK; bcnt_nxt = '0; phase_nxt = PH_TX_ACK; end
      end
      PH_TX_ACK: begin
        if (!cmd.data_level) begin wt_nxt = W_GAP; phase_nxt = PH_TX_GAP; end
        else if (wt_r == '0) begin
          err_nxt = 1'b1; ck_nxt = 1'b0; wt_nxt = W_GAP; phase_nxt = PH_TX_GAP;
        end else if (cmd.tick) begin
          if (bcnt_r + 1'b1 >= ACK_POLL) begin bcnt_nxt = '0; wt_nxt = wt_r - 1'b1; end
          else bcnt_nxt = bcnt_r + 1'b1;
        end
      end
      PH_TX_GAP: begin
        wt_nxt = wdec;
        if (tmo) begin
          case (kind_r)
            REQ_SEND_LAST: begin ck_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1; end
            REQ_LISTEN, REQ_TALK: begin
              if (err_r) begin phase_nxt = PH_IDLE; done = 1'b1; end
              else begin
                kind_nxt = (kind_r == REQ_LISTEN) ? K_LISTEN2 : K_TALK2;
                sh_nxt = sec_r; ck_nxt = 1'b0; phase_nxt = PH_TX_READY;
              end
            end
            REQ_UNLISTEN, REQ_UNTALK, K_LISTEN2, K_TALK2: begin
              if (err_r) begin phase_nxt = PH_IDLE; done = 1'b1; end
              else begin atn_nxt = 1'b0; wt_nxt = W_ATNREL; phase_nxt = PH_ATN_RELEASE; end
            end
            default: begin phase_nxt = PH_IDLE; done = 1'b1; end
          endcase
        end
      end
      PH_LAST_HIGH: if (cmd.data_level) phase_nxt = PH_LAST_LOW;
      PH_LAST_LOW: if (!cmd.data_level) begin ck_nxt = 1'b0; phase_nxt = PH_TX_READY; end
      PH_ATN_RELEASE: begin
        wt_nxt = wdec;
        if (tmo) begin
          if (kind_r == K_TALK2) begin
            dt_nxt = 1'b1; ck_nxt = 1'b0; wt_nxt = WAIT_W'(cfg.pullup_settle_us);
            phase_nxt = PH_TURN_SETTLE;
          end else if (kind_r == REQ_UNLISTEN || kind_r == REQ_UNTALK) begin
            atn_nxt = 1'b0; ck_nxt = 1'b0; dt_nxt = 1'b0; phase_nxt = PH_REL_CLK;
          end else begin phase_nxt = PH_IDLE; done = 1'b1; end
        end
      end
      PH_TURN_SETTLE: begin
        wt_nxt = wdec;
        if (tmo) phase_nxt = PH_TURN_WAIT;
      end
      PH_TURN_WAIT: if (!cmd.clk_level) begin phase_nxt = PH_IDLE; done = 1'b1; end
      PH_REL_CLK: if (cmd.clk_level) phase_nxt = PH_REL_DATA;
      PH_REL_DATA: if (cmd.data_level) begin phase_nxt = PH_IDLE; done = 1'b1; end
      PH_RX_READY: if (cmd.clk_level) begin
        dt_nxt = 1'b0; wt_nxt = W_EOI; bcnt_nxt = '0; phase_nxt = PH_RX_EOI;
      end
      PH_RX_EOI: begin
        if (!cmd.clk_level) begin sh_nxt = '0; bcnt_nxt = '0; phase_nxt = PH_RX_BIT_HIGH; end
        else if (wt_r == '0) begin
          eoi_nxt = 1'b1; dt_nxt = 1'b1; wt_nxt = W_BIT; phase_nxt = PH_RX_EOI_HOLD;
        end else if (cmd.tick) begin
          if (bcnt_r + 1'b1 >= EOI_POLL) begin bcnt_nxt = '0; wt_nxt = wt_r - 1'b1; end
          else bcnt_nxt = bcnt_r + 1'b1;
        end
      end
      PH_RX_EOI_HOLD: begin
        wt_nxt = wdec;
        if (tmo) begin dt_nxt = 1'b0; phase_nxt = PH_RX_EOI_START; end
      end
      PH_RX_EOI_START: if (!cmd.clk_level) begin
        sh_nxt = '0; bcnt_nxt = '0; phase_nxt = PH_RX_BIT_HIGH;
      end
      PH_RX_BIT_HIGH: if (cmd.clk_level) begin
        sh_nxt = {cmd.data_level, sh_r[7:1]}; phase_nxt = PH_RX_BIT_LOW;
      end
      PH_RX_BIT_LOW: if (!cmd.clk_level) begin
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r < 4'd7) phase_nxt = PH_RX_BIT_HIGH;
        else begin
          rcv_nxt = sh_r; dt_nxt = 1'b1;
          if (eoi_r) begin wt_nxt = W_BIT; phase_nxt = PH_RX_ACK_HOLD; end
          else begin phase_nxt = PH_IDLE; done = 1'b1; end
        end
      end
      PH_RX_ACK_HOLD: begin
        wt_nxt = wdec;
        if (tmo) begin dt_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1; end
      end
      PH_FRX_START: if (!cmd.clk_level) begin
        sh_nxt = '0; bcnt_nxt = '0; wt_nxt = f16; phase_nxt = PH_FRX_WAIT;
      end
      PH_FRX_WAIT: begin
        wt_nxt = wdec;
        if (tmo) begin
          sh_nxt = sh_r | (cmd.clk_level ? 8'h00 : frx_clk_mask(k))
                        | (cmd.data_level ? 8'h00 : frx_dat_mask(k));
          bcnt_nxt = bcnt_r + 1'b1;
          if (bcnt_r >= 4'd3) begin rcv_nxt = sh_nxt; phase_nxt = PH_FRX_END; end
          else wt_nxt = fc << 3;
        end
      end
      PH_FRX_END: if (cmd.clk_level) begin phase_nxt = PH_IDLE; done = 1'b1; end
      PH_FTX_START: if (!cmd.clk_level) begin dt_nxt = 1'b0; phase_nxt = PH_FTX_GO; end
      PH_FTX_GO: if (cmd.clk_level) begin
        bcnt_nxt = '0;
        ck_nxt = |(sh_r & ftx_clk_mask(2'd0));
        dt_nxt = |(sh_r & ftx_dat_mask(2'd0));
        wt_nxt = (fc << 2) + (fc << 1); phase_nxt = PH_FTX_WAIT;
      end
      PH_FTX_WAIT: begin
        wt_nxt = wdec;
        if (tmo) begin
          bcnt_nxt = bcnt_r + 1'b1;
          if (bcnt_r >= 4'd3) begin
            ck_nxt = 1'b0; dt_nxt = 1'b0; phase_nxt = PH_FTX_END;
          end else begin
            ck_nxt = |(sh_r & ftx_clk_mask(bcnt_nxt[1:0]));
            dt_nxt = |(sh_r & ftx_dat_mask(bcnt_nxt[1:0]));
            wt_nxt = (bcnt_r == 4'd0) ? (fc << 3) + fc : (fc << 2) + (fc << 1);
          end
        end
      end
      PH_FTX_END: if (cmd.clk_level) begin phase_nxt = PH_IDLE; done = 1'b1; end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= '0; bcnt_r <= '0; sh_r <= '0; sec_r <= '0;
      rcv_r <= '0; wt_r <= '0; eoi_r <= 1'b0; err_r <= 1'b0;
      atn_r <= 1'b0; ck_r <= 1'b0; dt_r <= 1'b0; oval_r <= 1'b0; res_r <= '0;
    end else begin
      if (cmd_take) begin
        phase_r <= phase_nxt; kind_r <= kind_nxt; bcnt_r <= bcnt_nxt; sh_r <= sh_nxt;
        sec_r <= sec_nxt; rcv_r <= rcv_nxt; wt_r <= wt_nxt; eoi_r <= eoi_nxt;
        err_r <= err_nxt; atn_r <= atn_nxt; ck_r <= ck_nxt; dt_r <= dt_nxt;
        oval_r <= 1'b1;
        res_r <= '{atn_nxt, ck_nxt, dt_nxt, phase_nxt != PH_IDLE, done,
                   rcv_nxt, eoi_nxt, err_nxt};
      end else if (!out_stall) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign out_valid = oval_r;
  assign out_item = res_r;

  `IEC_ASSERT_IMP(a_done_idle, out_valid && out_item.done_res, !out_item.busy_res,
                  "done pulse while still busy")
  `IEC_ASSERT_IMP(a_fast_count, phase_r == PH_FRX_WAIT, bcnt_r < 4'd4,
                  "fast receive step count out of range")
  `IEC_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_item),
                  "stalled result changed")
endmodule

// ===== sv/iec_serial_bus_controller.sv =====
// Top level of the serial bus controller: front end, queue, back end.
// Depends on iec_pkg, iec_front, iec_queue, iec_back.
//
// Usage: each input item is one bus sample (tick flag, CLK and DATA levels)
// with an optional command, offered on in_valid / in_stall. Each item gives
// exactly one result on out_valid / out_stall: the line pulls, busy, a
// one-item done pulse, last received byte, EOI and the sticky error flag.
// A command offered while busy is ignored, as are unknown command codes.
// A result passes through the front, which classifies combinationally, the
// two-entry queue, into which the item is written, and the sequencer, which
// writes the output register. Throughput: one item per cycle while out_stall
// is low, set by the single sequencer transition per item. When the receiver
// stalls, the result register holds, the queue fills and in_stall rises once
// it is full. Reset (rst_n low, synchronous): all lines released, idle,
// error clear, registers back to their defaults. The user must write
// configuration through cfg_we / cfg_index / cfg_data while the block is
// idle; the block itself does not enforce this.
module iec_serial_bus_controller #(
  parameter int ACK_TIMEOUT_STEPS = iec_pkg::ACK_TIMEOUT_STEPS_DEF,
  parameter int EOI_DETECT_STEPS = iec_pkg::EOI_DETECT_STEPS_DEF,
  parameter int ATN_RESPONSE_US = iec_pkg::ATN_RESPONSE_US_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  iec_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iec_pkg::out_item_t  out_data
);
  import iec_pkg::*;

  cmd_item_t cmd_w, q_rd;
  cfg_t cfg_w;
  logic q_full, q_empty, q_take;

  iec_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_item(in_data), .cmd(cmd_w), .cfg(cfg_w)
  );

  assign in_stall = q_full;

  iec_queue u_queue (
    .clk, .rst_n, .wr_en(in_valid && !q_full), .wr_data(cmd_w), .full(q_full),
    .rd_en(q_take), .rd_data(q_rd), .empty(q_empty)
  );

  iec_back #(
    .ACK_TIMEOUT_STEPS(ACK_TIMEOUT_STEPS), .EOI_DETECT_STEPS(EOI_DETECT_STEPS),
    .ATN_RESPONSE_US(ATN_RESPONSE_US)
  ) u_back (
    .clk, .rst_n, .cfg(cfg_w), .cmd_valid(!q_empty), .cmd(q_rd), .cmd_take(q_take),
    .out_valid, .out_stall, .out_item(out_data)
  );
endmodule

// ===== dv/testbench.sv =====
// Testbench for iec_serial_bus_controller: an acting bus device drives the
// sampled lines, a cycle model predicts every result. Depends on iec_pkg.
`timescale 1ns / 1ps
module testbench;
  import iec_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_ATN_WAIT, S_TX_READY, S_TX_NONEOI, S_TX_SETUP, S_TX_VALID,
    S_TX_SETTLE, S_TX_ACK, S_TX_GAP, S_LAST_HIGH, S_LAST_LOW,
    S_ATN_RELEASE, S_TURN_SETTLE, S_TURN_WAIT, S_REL_CLK, S_REL_DATA,
    S_RX_READY, S_RX_EOI, S_RX_EOI_HOLD, S_RX_EOI_START, S_RX_BIT_HIGH,
    S_RX_BIT_LOW, S_RX_ACK_HOLD, S_FRX_START, S_FRX_WAIT, S_FRX_END,
    S_FTX_START, S_FTX_GO, S_FTX_WAIT, S_FTX_END
  } bus_phase_t;

  localparam logic [2:0] L_ATN = 3'b001, L_CLK = 3'b010, L_DATA = 3'b100;
  localparam logic [7:0] RX_CLK_BIT [4] = '{8'h80, 8'h40, 8'h08, 8'h04};
  localparam logic [7:0] RX_DAT_BIT [4] = '{8'h20, 8'h10, 8'h02, 8'h01};
  localparam logic [7:0] TX_CLK_BIT [4] = '{8'h08, 8'h04, 8'h80, 8'h40};
  localparam logic [7:0] TX_DAT_BIT [4] = '{8'h02, 8'h01, 8'h20, 8'h10};
  // run length in items; the tail of the run has no idling
  localparam int ITEM_BUDGET = 1100;
  localparam int CALM_FROM = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  iec_serial_bus_controller i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bus model state
  bus_phase_t ph;
  logic [3:0] kind, bcnt;
  logic [7:0] sreg, sec_byte, rx_last;
  logic [10:0] wcnt;
  logic eoi_r, err_r, done_r;
  logic [2:0] pulls;
  cfg_t regs;

  out_item_t bus_results[$];
  int mismatches = 0;
  int items_sent = 0;
  bit calm = 0;
  // device behaviour for the command under way
  bit dev_atn_ok, dev_ack_ok, dev_eoi;

  function automatic void set_pull(logic [2:0] m, logic on);
    pulls = on ? (pulls | m) : (pulls & ~m);
  endfunction

  function automatic logic tick_wait(logic t);
    if (wcnt != 0 && t) wcnt--;
    return wcnt == 0;
  endfunction

  function automatic void cmd_done();
    ph = S_IDLE;
    done_r = 1'b1;
  endfunction

  function automatic void tx_start(logic [7:0] b);
    sreg = b;
    set_pull(L_CLK, 1'b0);
    ph = S_TX_READY;
  endfunction

  function automatic void tx_fast_drive();
    set_pull(L_CLK, (sreg & TX_CLK_BIT[bcnt[1:0]]) != 0);
    set_pull(L_DATA, (sreg & TX_DAT_BIT[bcnt[1:0]]) != 0);
  endfunction

  function automatic void byte_sent();
    case (kind)
      REQ_SEND_LAST: begin
        set_pull(L_CLK, 1'b0);
        cmd_done();
      end
      REQ_LISTEN, REQ_TALK: begin
        if (err_r) cmd_done();
        else begin
          kind = (kind == REQ_LISTEN) ? K_LISTEN2 : K_TALK2;
          tx_start(sec_byte);
        end
      end
      REQ_UNLISTEN, REQ_UNTALK, K_LISTEN2, K_TALK2: begin
        if (err_r) cmd_done();
        else begin
          set_pull(L_ATN, 1'b0);
          wcnt = 11'd20;
          ph = S_ATN_RELEASE;
        end
      end
      default: cmd_done();
    endcase
  endfunction

  function automatic void take_cmd(in_item_t it);
    bcnt = 0;
    case (it.req_type)
      REQ_SEND: begin kind = REQ_SEND; tx_start(it.tx_byte); end
      REQ_SEND_LAST: begin
        kind = REQ_SEND_LAST; sreg = it.tx_byte;
        set_pull(L_CLK, 1'b0); ph = S_LAST_HIGH;
      end
      REQ_RECV: begin kind = REQ_RECV; eoi_r = 1'b0; ph = S_RX_READY; end
      REQ_LISTEN, REQ_TALK, REQ_UNLISTEN, REQ_UNTALK: begin
        kind = it.req_type;
        case (it.req_type)
          REQ_LISTEN: sreg = regs.listen_code + {3'd0, it.device_number};
          REQ_TALK: sreg = regs.talk_code + {3'd0, it.device_number};
          REQ_UNLISTEN: sreg = regs.unlisten_code;
          default: sreg = regs.untalk_code;
        endcase
        sec_byte = regs.open_channel_code + {4'd0, it.secondary_address};
        set_pull(L_ATN | L_CLK, 1'b1);
        wcnt = 11'd1000;
        ph = S_ATN_WAIT;
      end
      REQ_FRX: begin kind = REQ_FRX; ph = S_FRX_START; end
      REQ_FTX: begin kind = REQ_FTX; sreg = it.tx_byte; ph = S_FTX_START; end
      REQ_CLR: begin err_r = 1'b0; cmd_done(); end
      default: ;
    endcase
  endfunction

  function automatic void bus_advance(logic t, logic cl, logic dt);
    logic [10:0] fc;
    fc = 11'(regs.ticks_per_fast_cycle);
    case (ph)
      S_ATN_WAIT: if (tick_wait(t)) begin
        if (dt) begin err_r = 1'b1; set_pull(L_ATN | L_CLK, 1'b0); end
        if (err_r) cmd_done(); else tx_start(sreg);
      end
      S_TX_READY: if (dt) begin wcnt = 11'd40; ph = S_TX_NONEOI; end
      S_TX_NONEOI: if (tick_wait(t)) begin
        set_pull(L_CLK, 1'b1);
        bcnt = 0;
        set_pull(L_DATA, !sreg[0]);
        wcnt = 11'd60; ph = S_TX_SETUP;
      end
      S_TX_SETUP: if (tick_wait(t)) begin
        set_pull(L_CLK, 1'b0); wcnt = 11'd60; ph = S_TX_VALID;
      end
      S_TX_VALID: if (tick_wait(t)) begin
        set_pull(L_CLK, 1'b1);
        sreg = sreg >> 1;
        bcnt++;
        if (bcnt < 8) begin
          set_pull(L_DATA, !sreg[0]); wcnt = 11'd60; ph = S_TX_SETUP;
        end else begin
          set_pull(L_DATA, 1'b0); wcnt = 11'(regs.pullup_settle_us); ph = S_TX_SETTLE;
        end
      end
      S_TX_SETTLE: if (tick_wait(t)) begin
        wcnt = 11'd249; bcnt = 0; ph = S_TX_ACK;
      end
      S_TX_ACK: begin
        if (!dt) begin wcnt = 11'd100; ph = S_TX_GAP; end
        else if (wcnt == 0) begin
          err_r = 1'b1; set_pull(L_CLK, 1'b0); wcnt = 11'd100; ph = S_TX_GAP;
        end else if (t) begin
          bcnt++;
          if (bcnt >= 4) begin bcnt = 0; wcnt--; end
        end
      end
      S_TX_GAP: if (tick_wait(t)) byte_sent();
      S_LAST_HIGH: if (dt) ph = S_LAST_LOW;
      S_LAST_LOW: if (!dt) tx_start(sreg);
      S_ATN_RELEASE: if (tick_wait(t)) begin
        if (kind == K_TALK2) begin
          set_pull(L_DATA, 1'b1); set_pull(L_CLK, 1'b0);
          wcnt = 11'(regs.pullup_settle_us); ph = S_TURN_SETTLE;
        end else if (kind == REQ_UNLISTEN || kind == REQ_UNTALK) begin
          set_pull(L_ATN | L_CLK | L_DATA, 1'b0); ph = S_REL_CLK;
        end else cmd_done();
      end
      S_TURN_SETTLE: if (tick_wait(t)) ph = S_TURN_WAIT;
      S_TURN_WAIT: if (!cl) cmd_done();
      S_REL_CLK: if (cl) ph = S_REL_DATA;
      S_REL_DATA: if (dt) cmd_done();
      S_RX_READY: if (cl) begin
        set_pull(L_DATA, 1'b0); wcnt = 11'd24; bcnt = 0; ph = S_RX_EOI;
      end
      S_RX_EOI: begin
        if (!cl) begin sreg = 0; bcnt = 0; ph = S_RX_BIT_HIGH; end
        else if (wcnt == 0) begin
          eoi_r = 1'b1; set_pull(L_DATA, 1'b1); wcnt = 11'd60; ph = S_RX_EOI_HOLD;
        end else if (t) begin
          bcnt++;
          if (bcnt >= 10) begin bcnt = 0; wcnt--; end
        end
      end
      S_RX_EOI_HOLD: if (tick_wait(t)) begin
        set_pull(L_DATA, 1'b0); ph = S_RX_EOI_START;
      end
      S_RX_EOI_START: if (!cl) begin sreg = 0; bcnt = 0; ph = S_RX_BIT_HIGH; end
      S_RX_BIT_HIGH: if (cl) begin sreg = {dt, sreg[7:1]}; ph = S_RX_BIT_LOW; end
      S_RX_BIT_LOW: if (!cl) begin
        bcnt++;
        if (bcnt < 8) ph = S_RX_BIT_HIGH;
        else begin
          rx_last = sreg;
          set_pull(L_DATA, 1'b1);
          if (eoi_r) begin wcnt = 11'd60; ph = S_RX_ACK_HOLD; end
          else cmd_done();
        end
      end
      S_RX_ACK_HOLD: if (tick_wait(t)) begin set_pull(L_DATA, 1'b0); cmd_done(); end
      S_FRX_START: if (!cl) begin
        sreg = 0; bcnt = 0; wcnt = 11'(16 * fc); ph = S_FRX_WAIT;
      end
      S_FRX_WAIT: if (tick_wait(t)) begin
        if (!cl) sreg |= RX_CLK_BIT[bcnt[1:0]];
        if (!dt) sreg |= RX_DAT_BIT[bcnt[1:0]];
        bcnt++;
        if (bcnt >= 4) begin rx_last = sreg; ph = S_FRX_END; end
        else wcnt = 11'(8 * fc);
      end
      S_FRX_END: if (cl) cmd_done();
      S_FTX_START: if (!cl) begin set_pull(L_DATA, 1'b0); ph = S_FTX_GO; end
      S_FTX_GO: if (cl) begin
        bcnt = 0; tx_fast_drive(); wcnt = 11'(6 * fc); ph = S_FTX_WAIT;
      end
      S_FTX_WAIT: if (tick_wait(t)) begin
        bcnt++;
        if (bcnt >= 4) begin set_pull(L_CLK | L_DATA, 1'b0); ph = S_FTX_END; end
        else begin
          tx_fast_drive();
          wcnt = ((bcnt == 1) ? 11'd9 : 11'd6) * fc;
        end
      end
      S_FTX_END: if (cl) cmd_done();
      default: ph = S_IDLE;
    endcase
  endfunction

  function automatic out_item_t bus_step(in_item_t it);
    out_item_t r;
    done_r = 1'b0;
    if (ph == S_IDLE) begin
      if (it.req_valid) take_cmd(it);
    end else bus_advance(it.tick, it.clk_level, it.data_level);
    r.atn_pull = pulls[0];
    r.clk_pull = pulls[1];
    r.data_pull = pulls[2];
    r.busy_res = (ph != S_IDLE);
    r.done_res = done_r;
    r.rx_byte = rx_last;
    r.eoi_seen = eoi_r;
    r.error_flag = err_r;
    return r;
  endfunction

  // one item through the input handshake, then into the model
  task automatic send_item(in_item_t it);
    calm = (items_sent >= CALM_FROM);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    bus_results.push_back(bus_step(it));
    @(negedge clk);
  endtask

  // sampled lines as a device on the bus would answer, with some noise
  function automatic in_item_t bus_sample();
    in_item_t it;
    it = in_item_t'($urandom);
    it.req_valid = ($urandom_range(0, 15) == 0);
    it.tick = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 7) != 0) begin
      case (ph)
        S_ATN_WAIT: it.data_level = !dev_atn_ok;
        S_TX_READY, S_LAST_HIGH, S_REL_DATA: it.data_level = 1'b1;
        S_TX_ACK: it.data_level = !dev_ack_ok;
        S_LAST_LOW: it.data_level = 1'b0;
        S_RX_READY, S_RX_BIT_HIGH, S_FRX_END, S_FTX_GO, S_FTX_END, S_REL_CLK:
          it.clk_level = 1'b1;
        S_RX_EOI: it.clk_level = dev_eoi;
        S_TURN_WAIT, S_RX_EOI_START, S_RX_BIT_LOW, S_FRX_START, S_FTX_START:
          it.clk_level = 1'b0;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic run_cmd(logic [3:0] op, logic [7:0] txb, logic [4:0] dev,
                         logic [3:0] sec, bit atn_ok, bit ack_ok, bit eoi);
    in_item_t it;
    if (items_sent >= ITEM_BUDGET) return;
    it = in_item_t'($urandom);
    it.req_valid = 1'b1;
    it.req_type = op;
    it.tx_byte = txb;
    it.device_number = dev;
    it.secondary_address = sec;
    dev_atn_ok = atn_ok;
    dev_ack_ok = ack_ok;
    dev_eoi = eoi;
    send_item(it);
    while (ph != S_IDLE && items_sent < ITEM_BUDGET) send_item(bus_sample());
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    if (items_sent >= ITEM_BUDGET) return;
    in_valid <= 1'b0;
    while (bus_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PULLUP: regs.pullup_settle_us = val;
      CFG_FAST: regs.ticks_per_fast_cycle = val[3:0];
      CFG_LISTEN: regs.listen_code = val;
      CFG_TALK: regs.talk_code = val;
      CFG_UNLISTEN: regs.unlisten_code = val;
      CFG_UNTALK: regs.untalk_code = val;
      default: regs.open_channel_code = val;
    endcase
  endtask

  task automatic set_all_regs(logic [7:0] p, logic [7:0] f, logic [7:0] c);
    write_reg(CFG_PULLUP, p);
    write_reg(CFG_FAST, f);
    write_reg(CFG_LISTEN, c);
    write_reg(CFG_TALK, c);
    write_reg(CFG_UNLISTEN, c);
    write_reg(CFG_UNTALK, c);
    write_reg(CFG_OPEN, c);
  endtask

  task automatic test_zero_fast_cycle();
    set_all_regs(8'd255, 8'd0, 8'd0);
    run_cmd(REQ_FRX, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_FTX, 8'h5A, 0, 0, 1, 1, 0);
    set_all_regs(8'd5, 8'd1, 8'd255);            // code plus number wraps
  endtask

  // unknown code and error clear first, then each bus transfer in turn
  task automatic test_each_command();
    run_cmd(4'd15, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_CLR, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_RECV, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_FRX, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_FTX, 8'hFF, 0, 0, 1, 1, 0);
    run_cmd(REQ_RECV, 8'h00, 0, 0, 1, 1, 1);
    run_cmd(REQ_SEND, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_SEND, 8'hFF, 0, 0, 1, 1, 0);
    run_cmd(REQ_SEND_LAST, 8'hA5, 0, 0, 1, 1, 0);
    run_cmd(REQ_LISTEN, 8'h00, 5'd31, 4'd15, 1, 1, 0);
    run_cmd(REQ_TALK, 8'h00, 5'd0, 4'd0, 1, 1, 0);
    run_cmd(REQ_UNLISTEN, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_UNTALK, 8'h00, 0, 0, 1, 1, 0);
  endtask

  task automatic test_errors();
    run_cmd(REQ_SEND, 8'h3C, 0, 0, 1, 0, 0);      // no acknowledge
    run_cmd(REQ_LISTEN, 8'h00, 5'd8, 4'd2, 1, 1, 0); // aborts on sticky error
    run_cmd(REQ_CLR, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_TALK, 8'h00, 5'd9, 4'd1, 0, 1, 0); // nobody answers ATN
    run_cmd(REQ_CLR, 8'h00, 0, 0, 1, 1, 0);
    run_cmd(REQ_UNTALK, 8'h00, 0, 0, 1, 0, 0);     // ATN left pulled
    run_cmd(REQ_CLR, 8'h00, 0, 0, 1, 1, 0);
  endtask

  task automatic test_random_commands(int n);
    logic [3:0] op;
    repeat (n) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      run_cmd(op, 8'($urandom), 5'($urandom), 4'($urandom),
              $urandom_range(0, 11) != 0, $urandom_range(0, 7) != 0,
              $urandom_range(0, 1) != 0);
    end
  endtask

  // result side stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data !== bus_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p got %p", bus_results[0], out_data);
        end
        void'(bus_results.pop_front());
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 2000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    ph = S_IDLE; kind = 0; sreg = 0; bcnt = 0; wcnt = 0; sec_byte = 0;
    rx_last = 0; eoi_r = 0; err_r = 0; pulls = 0; done_r = 0;
    regs = '{8'd5, 4'd1, 8'd32, 8'd64, 8'd63, 8'd95, 8'd96};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_zero_fast_cycle();
    test_each_command();
    test_errors();
    test_random_commands(30);
    in_valid <= 1'b0;
    while (bus_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
